>>> design/bresenham_line_rasterizer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the line rasterizer
// Clocked, reset-qualified assertion forms shared by checker files.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_MACROS_SVH

// property must hold at every clock edge outside reset
`define BLR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define BLR_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> design/blr_pkg.sv
// ----------------------------------------------------------------------------
// blr_pkg
// Shared constants and types of the Bresenham line rasterizer.
// ----------------------------------------------------------------------------
package blr_pkg;

    localparam int COORD_BITS_DEFAULT = 12;
    localparam int DIM_BITS           = 13;
    localparam int ADDR_BITS          = 24;
    localparam int COLOR_BITS         = 32;
    localparam int CFG_INDEX_BITS     = 8;
    localparam int CFG_DATA_BITS      = 32;

    localparam logic [DIM_BITS-1:0]   WIDTH_RESET  = 13'd1024;
    localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = 13'd768;
    localparam logic [COLOR_BITS-1:0] COLOR_RESET  = 32'h00FF_FFFF;

    typedef enum logic
    {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    typedef enum logic [CFG_INDEX_BITS-1:0]
    {
        CFG_SCREEN_WIDTH  = 8'd0,
        CFG_SCREEN_HEIGHT = 8'd1,
        CFG_DRAW_COLOR    = 8'd2
    } cfg_reg_t;

endpackage

>>> design/bresenham_line_rasterizer.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// Integer Bresenham line stepper with clipping and framebuffer addressing.
// ----------------------------------------------------------------------------
// A start beat (opcode 0) loads the endpoints with no pixel out. Each advance
// beat on an active line gives one pixel in the cycle after it is taken; the
// block takes one command per cycle unless a held pixel stalls it, with the
// error term update and the row-times-width address multiply feeding the
// pixel register. The pixel register frees whenever its beat is taken, so
// a new command is accepted in the same cycle the pending pixel leaves.
module bresenham_line_rasterizer
    import blr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,

    input  logic                      cmd_valid,
    output logic                      cmd_ready,
    input  logic                      opcode,
    input  logic [COORD_BITS-1:0]     from_x,
    input  logic [COORD_BITS-1:0]     from_y,
    input  logic [COORD_BITS-1:0]     to_x,
    input  logic [COORD_BITS-1:0]     to_y,

    output logic                      pix_valid,
    input  logic                      pix_ready,
    output logic [COORD_BITS-1:0]     pixel_x,
    output logic [COORD_BITS-1:0]     pixel_y,
    output logic [ADDR_BITS-1:0]      word_address,
    output logic [COLOR_BITS-1:0]     color,
    output logic                      visible,
    output logic                      last
);

    localparam int EW   = COORD_BITS + 3;
    localparam int PW   = COORD_BITS + 1;
    localparam int DW   = COORD_BITS + 1;
    localparam int MW   = COORD_BITS + DIM_BITS + 1;
    localparam int AW   = (MW > ADDR_BITS) ? MW : ADDR_BITS;
    localparam int CW   = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;

    function automatic logic [COORD_BITS-1:0] step_coord(
        input logic [COORD_BITS-1:0] v,
        input logic                  negative
    );
        step_coord = negative ? (v - 1'b1) : (v + 1'b1);
    endfunction

    // configuration
    logic [DIM_BITS-1:0]   screen_width_reg;
    logic [DIM_BITS-1:0]   screen_height_reg;
    logic [COLOR_BITS-1:0] draw_color_reg;

    // line state
    logic [COORD_BITS-1:0] cur_x_reg,  cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg,  cur_y_next;
    logic signed [EW-1:0]  err_reg,    err_next;
    logic [COORD_BITS-1:0] abs_dx_reg, abs_dx_next;
    logic [COORD_BITS-1:0] abs_dy_reg, abs_dy_next;
    logic                  sxn_reg,    sxn_next;
    logic                  syn_reg,    syn_next;
    logic                  x_major_reg, x_major_next;
    logic [PW-1:0]         left_reg,   left_next;
    logic                  active_reg, active_next;

    // pixel register
    logic                  pix_valid_reg,  pix_valid_next;
    logic [COORD_BITS-1:0] pixel_x_reg;
    logic [COORD_BITS-1:0] pixel_y_reg;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [COLOR_BITS-1:0] color_reg;
    logic                  visible_reg;
    logic                  last_reg;

    logic                  cmd_fire;
    logic                  emit;
    logic signed [DW-1:0]  dx, dy;
    logic [COORD_BITS-1:0] adx, ady, major_d, minor_d, s_major, s_minor;
    logic signed [EW-1:0]  err_init;
    logic [AW-1:0]         addr_wide;
    logic                  vis;
    logic [PW-1:0]         left_dec;

    assign cfg_ready = 1'b1;
    assign cmd_ready = !pix_valid_reg || pix_ready;
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign emit      = cmd_fire && (op_t'(opcode) == OP_ADVANCE) && active_reg;

    always_comb
    begin
        dx = $signed({1'b0, to_x}) - $signed({1'b0, from_x});
        dy = $signed({1'b0, to_y}) - $signed({1'b0, from_y});
        adx = dx[DW-1] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        ady = dy[DW-1] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        major_d = (adx > ady) ? adx : ady;
        minor_d = (adx > ady) ? ady : adx;
        err_init = $signed(EW'({minor_d, 1'b0})) - $signed(EW'(major_d));

        s_major = x_major_reg ? abs_dx_reg : abs_dy_reg;
        s_minor = x_major_reg ? abs_dy_reg : abs_dx_reg;

        addr_wide = AW'(cur_y_reg) * AW'(screen_width_reg) + AW'(cur_x_reg);
        vis = (CW'(cur_x_reg) < CW'(screen_width_reg))
           && (CW'(cur_y_reg) < CW'(screen_height_reg));
        left_dec = (left_reg != '0) ? (left_reg - 1'b1) : left_reg;
    end

    always_comb
    begin
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        err_next     = err_reg;
        abs_dx_next  = abs_dx_reg;
        abs_dy_next  = abs_dy_reg;
        sxn_next     = sxn_reg;
        syn_next     = syn_reg;
        x_major_next = x_major_reg;
        left_next    = left_reg;
        active_next  = active_reg;

        if (cmd_fire && (op_t'(opcode) == OP_START))
        begin
            cur_x_next   = from_x;
            cur_y_next   = from_y;
            abs_dx_next  = adx;
            abs_dy_next  = ady;
            sxn_next     = dx[DW-1] || (dx == '0);
            syn_next     = dy[DW-1] || (dy == '0);
            x_major_next = adx > ady;
            err_next     = err_init;
            left_next    = PW'(major_d) + 1'b1;
            active_next  = 1'b1;
        end
        else if (emit)
        begin
            if (x_major_reg)
            begin
                cur_x_next = step_coord(cur_x_reg, sxn_reg);
                if (!err_reg[EW-1])
                begin
                    cur_y_next = step_coord(cur_y_reg, syn_reg);
                end
            end
            else
            begin
                cur_y_next = step_coord(cur_y_reg, syn_reg);
                if (!err_reg[EW-1])
                begin
                    cur_x_next = step_coord(cur_x_reg, sxn_reg);
                end
            end
            err_next = err_reg + $signed(EW'({s_minor, 1'b0}))
                     - (err_reg[EW-1] ? '0 : $signed(EW'({s_major, 1'b0})));
            left_next   = left_dec;
            active_next = (left_dec != '0);
        end
    end

    always_comb
    begin
        pix_valid_next = pix_valid_reg && !pix_ready;
        if (cmd_fire)
        begin
            pix_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= WIDTH_RESET;
            screen_height_reg <= HEIGHT_RESET;
            draw_color_reg    <= COLOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[DIM_BITS-1:0];
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[DIM_BITS-1:0];
                CFG_DRAW_COLOR:    draw_color_reg    <= cfg_data[COLOR_BITS-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            err_reg       <= '0;
            abs_dx_reg    <= '0;
            abs_dy_reg    <= '0;
            sxn_reg       <= 1'b0;
            syn_reg       <= 1'b0;
            x_major_reg   <= 1'b0;
            left_reg      <= '0;
            active_reg    <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            err_reg       <= err_next;
            abs_dx_reg    <= abs_dx_next;
            abs_dy_reg    <= abs_dy_next;
            sxn_reg       <= sxn_next;
            syn_reg       <= syn_next;
            x_major_reg   <= x_major_next;
            left_reg      <= left_next;
            active_reg    <= active_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    // pixel payload, loaded only on a producing beat
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pixel_x_reg <= cur_x_reg;
            pixel_y_reg <= cur_y_reg;
            addr_reg    <= addr_wide[ADDR_BITS-1:0];
            color_reg   <= draw_color_reg;
            visible_reg <= vis;
            last_reg    <= (left_reg == PW'(1));
        end
    end

    assign pix_valid    = pix_valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign word_address = addr_reg;
    assign color        = color_reg;
    assign visible      = visible_reg;
    assign last         = last_reg;

endmodule

>>> design/blr_checker.sv
// ----------------------------------------------------------------------------
// blr_checker
// Port-level checks of the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "bresenham_line_rasterizer_macros.svh"

module blr_checker
    import blr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic                      cmd_valid,
    input logic                      cmd_ready,
    input logic                      opcode,
    input logic                      pix_valid,
    input logic                      pix_ready,
    input logic [COORD_BITS-1:0]     pixel_x,
    input logic [COORD_BITS-1:0]     pixel_y,
    input logic [ADDR_BITS-1:0]      word_address,
    input logic [COLOR_BITS-1:0]     color,
    input logic                      visible,
    input logic                      last
);

    logic start_beat;
    logic pix_free;
    logic pix_stall;
    logic [2*COORD_BITS+ADDR_BITS+COLOR_BITS+1:0] pix_payload;

    assign start_beat  = cmd_valid && cmd_ready && (op_t'(opcode) == OP_START);
    assign pix_free    = !pix_valid || pix_ready;
    assign pix_stall   = pix_valid && !pix_ready;
    assign pix_payload = {pixel_x, pixel_y, word_address, color, visible, last};

    `BLR_ASSERT(a_pix_hold, pix_stall |=> pix_valid && $stable(pix_payload), "pixel beat not held")
    `BLR_ASSERT(a_start_silent, start_beat && pix_free |=> !pix_valid, "start gave a pixel")
    `BLR_NEVER(a_ready_when_empty, !pix_valid && !cmd_ready, "empty but not ready")
    `BLR_NEVER(a_cfg_ready, cfg_valid && !cfg_ready, "config write stalled")

endmodule

bind bresenham_line_rasterizer blr_checker #(.COORD_BITS(COORD_BITS)) u_blr_checker (.*);
